### src/ecpb_pkg.sv
package ecpb_pkg;

    localparam int MAX_COLORS  = 256;
    localparam int SMALL_LIMIT = 16;

    localparam int COLOR_W = 32;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = $clog2(MAX_COLORS);
    localparam int CNT_W   = $clog2(MAX_COLORS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FINISH
    } ecpb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic hit;
        logic step;
        logic commit;
    } ecpb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic overflow;
        logic empty;
        logic match;
        logic last_entry;
        logic out_free;
    } ecpb_status_t;

endpackage

### src/ecpb_ctrl.sv
module ecpb_ctrl
    import ecpb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ecpb_status_t status,
    output ecpb_cmd_t    cmd
);

    ecpb_state_t state_reg;
    ecpb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.overflow || status.empty)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.match || status.last_entry)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_READ:
            begin
                cmd = '0;
            end
            ST_CMP:
            begin
                cmd.hit  = status.match;
                cmd.step = !status.match && !status.last_entry;
            end
            ST_FINISH:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/ecpb_datapath.sv
module ecpb_datapath
    import ecpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ecpb_cmd_t          cmd,
    output ecpb_status_t       status,
    input  logic [COLOR_W-1:0] color,
    input  logic               last_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_index,
    output logic               new_color,
    output logic [CNT_W-1:0]   unique_count,
    output logic               small_palette,
    output logic               overflow,
    output logic               end_of_image
);

    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_COLORS);
    localparam logic [CNT_W-1:0] CNT_SMALL = CNT_W'(SMALL_LIMIT);

    logic [COLOR_W-1:0] color_mem [MAX_COLORS];
    logic [COLOR_W-1:0] rd_data_reg;

    logic [COLOR_W-1:0] color_reg;
    logic               last_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               overflow_reg;
    logic               out_valid_reg;

    logic [PIX_W-1:0]   pix_reg;
    logic               new_reg;
    logic [CNT_W-1:0]   ucount_reg;
    logic               small_reg;
    logic               ovf_out_reg;
    logic               eoi_reg;

    logic               room;
    logic               append;
    logic               set_ovf;
    logic [IDX_W-1:0]   res_idx;
    logic [CNT_W-1:0]   count_next;
    logic               overflow_next;

    assign room          = count_reg < CNT_MAX;
    assign append        = !overflow_reg && !hit_reg && room;
    assign set_ovf       = !overflow_reg && !hit_reg && !room;
    assign overflow_next = overflow_reg || set_ovf;
    assign count_next    = append ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        priority if (overflow_next)
        begin
            res_idx = '0;
        end
        else if (hit_reg)
        begin
            res_idx = idx_reg;
        end
        else
        begin
            res_idx = count_reg[IDX_W-1:0];
        end
    end

    assign status.overflow   = overflow_reg;
    assign status.empty      = count_reg == '0;
    assign status.match      = rd_data_reg == color_reg;
    assign status.last_entry = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Table storage: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && append)
        begin
            color_mem[count_reg[IDX_W-1:0]] <= color_reg;
        end
        rd_data_reg <= color_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            color_reg <= color;
            last_reg  <= last_pixel;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.hit)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                count_reg     <= last_reg ? '0 : count_next;
                overflow_reg  <= last_reg ? 1'b0 : overflow_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pix_reg     <= PIX_W'(res_idx);
            new_reg     <= append;
            ucount_reg  <= count_next;
            small_reg   <= !overflow_next && (count_next <= CNT_SMALL);
            ovf_out_reg <= overflow_next;
            eoi_reg     <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_index   = pix_reg;
    assign new_color     = new_reg;
    assign unique_count  = ucount_reg;
    assign small_palette = small_reg;
    assign overflow      = ovf_out_reg;
    assign end_of_image  = eoi_reg;

endmodule

### src/exact_color_palette_builder_top.sv
// A beat is taken in the idle state. With the table empty or overflow set it goes straight
// to the finish state; otherwise read and compare states alternate over the table entries
// until a match or the last stored entry. The finish state registers the result once the
// output register is free. One beat at a time: the next input beat is taken only after the
// result is registered; the table's single read port lets the walk read one entry at a time.
// Reset (rst_n low, asynchronous) empties the table, clears the overflow flag and out_valid.
module exact_color_palette_builder_top
    import ecpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COLOR_W-1:0] color,
    input  logic               last_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIX_W-1:0]   pixel_index,
    output logic               new_color,
    output logic [CNT_W-1:0]   unique_count,
    output logic               small_palette,
    output logic               overflow,
    output logic               end_of_image
);

    // The controller walks the table one entry per read/compare pair, starting at
    // index zero, and stops at the first match or after the last stored entry.
    // The datapath owns the color table, the running count and the sticky overflow
    // flag; it updates them only when the result is written to the output register.
    // Because the output register holds the finished beat, the controller can take
    // a new pixel while the previous result still waits to be taken downstream.
    // An end-of-image beat clears the count and flag at that same commit, which
    // empties the table without touching its storage.

    ecpb_cmd_t    cmd;
    ecpb_status_t status;

    ecpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ecpb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .color         (color),
        .last_pixel    (last_pixel),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_index   (pixel_index),
        .new_color     (new_color),
        .unique_count  (unique_count),
        .small_palette (small_palette),
        .overflow      (overflow),
        .end_of_image  (end_of_image)
    );

endmodule

### src/ecpb_checker.sv
module ecpb_checker
    import ecpb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PIX_W-1:0]   pixel_index,
    input logic               new_color,
    input logic [CNT_W-1:0]   unique_count,
    input logic               small_palette,
    input logic               overflow,
    input logic               end_of_image
);

    // A stalled result beat stays valid with the same index, count, overflow and end-of-image.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_index)
            && $stable(unique_count) && $stable(overflow) && $stable(end_of_image))
        else $error("result beat changed while stalled");

    // After an input beat is taken, the block is busy with it.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second pixel accepted while one is in flight");

    // A new color is appended at the end of the table.
    a_new_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_color |->
            unique_count == ({1'b0, pixel_index} + CNT_W'(1)) && !overflow)
        else $error("new color index does not match count");

    // An overflowed image reports a full table and index zero.
    a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            pixel_index == '0 && !new_color && !small_palette
            && unique_count == CNT_W'(MAX_COLORS))
        else $error("overflow result fields inconsistent");

endmodule

bind exact_color_palette_builder_top ecpb_checker u_ecpb_checker (.*);
